>>> sv/tfrx_pkg.sv
// shared types and constants of the tail framed receiver
`default_nettype none

package tfrx_pkg;

  // input item: event code and received byte
  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_done;
    logic [6:0] frame_size;
    logic       overflow;
  } out_item_t;

  // event codes
  localparam logic CMD_RX_BYTE  = 1'b0;
  localparam logic CMD_TX_READY = 1'b1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_FIRST  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_SECOND = 1'b1;

  localparam logic [7:0] TAIL_FIRST_RESET  = 8'd13;
  localparam logic [7:0] TAIL_SECOND_RESET = 8'd10;

  // operation passed from the front to the back, addresses travel beside it
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       send;
    logic       done;
    logic       ovf;
    logic [7:0] wdata;
    logic [6:0] len;
  } op_t;

  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

>>> sv/tail_framed_receiver_with_echo.sv
// frame receiver with two-byte terminator and echo of completed frames
//
// in channel (in_valid/in_ready/in_item) carries one event per item: a
// received byte or a transmitter-free notice. out channel
// (out_valid/out_ready/out_item) carries at most one result per event.
// bytes gather into one of two banks of BUF_DEPTH bytes; a frame ends on the
// configured terminator pair, never matched on its first byte.
// cfg_write/cfg_index/cfg_data set the two terminator bytes (13, 10 at reset).
// throughput: one item per cycle sustained while out_ready stays high. the front
// updates all frame and echo state in the accept cycle and pushes any resulting
// memory operation into a four-entry queue; the back pops one operation a cycle
// unless a result waits on a stalled receiver, does the bank write and read, and
// registers the result. with an empty queue an operation is written into the
// queue, then popped by the back and registered there as out_valid rises.
// when the receiver stalls, write-only operations still drain; once the
// queue fills, in_ready drops until results move again.
// reset (synchronous) returns the terminator, frame state and queue to idle;
// the bank memory is not cleared and needs no clearing pass.
`default_nettype none

module tail_framed_receiver_with_echo
  import tfrx_pkg::*;
#(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_item,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data
);

  localparam int AW = $clog2(2 * BUF_DEPTH);
  localparam int QW = $bits(op_t) + 2 * AW;

  logic          push, push_ready;
  op_t           f_op, b_op;
  logic [AW-1:0] f_waddr, f_raddr, b_waddr, b_raddr;
  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  tfrx_front #(
    .BUF_DEPTH(BUF_DEPTH),
    .AW       (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_ready(push_ready),
    .op        (f_op),
    .waddr     (f_waddr),
    .raddr     (f_raddr)
  );

  tfrx_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(push),
    .wr_ready(push_ready),
    .wr_data ({f_op, f_waddr, f_raddr}),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_data)
  );

  assign {b_op, b_waddr, b_raddr} = q_data;

  tfrx_back #(
    .BUF_DEPTH(BUF_DEPTH),
    .AW       (AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .op       (b_op),
    .waddr    (b_waddr),
    .raddr    (b_raddr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

>>> sv/tfrx_front.sv
// front part: frame tracking, terminator match, echo bookkeeping
`default_nettype none

module tfrx_front
  import tfrx_pkg::*;
#(
  parameter int BUF_DEPTH = 64,
  parameter int AW        = $clog2(2 * BUF_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_item,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data,
  output logic                        push,
  input  wire logic                   push_ready,
  output op_t                         op,
  output logic [AW-1:0]               waddr,
  output logic [AW-1:0]               raddr
);

  localparam int CW = $clog2(BUF_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_READY,
    PH_RECEIVING,
    PH_HALF,
    PH_TAIL
  } phase_t;

  phase_t        rx_phase, rx_phase_next;
  logic [CW-1:0] rx_count, rx_count_next;
  logic          rx_overflowed, rx_overflowed_next;
  logic          bank_select, bank_select_next;
  logic [CW-1:0] tx_remaining, tx_remaining_next;
  logic [CW-1:0] tx_index, tx_index_next;
  logic [7:0]    tail_first, tail_second;

  logic          accept;
  logic          start;
  logic          complete;
  logic [CW-1:0] base_count;
  logic          base_ovf;
  logic [CW-1:0] count_new;
  logic          ovf_new;

  function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [CW-1:0] idx);
    logic [AW-1:0] a;
    a = AW'(idx);
    if (bank) a = a + AW'(BUF_DEPTH);
    return a;
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rx_phase_next      = rx_phase;
    rx_count_next      = rx_count;
    rx_overflowed_next = rx_overflowed;
    bank_select_next   = bank_select;
    tx_remaining_next  = tx_remaining;
    tx_index_next      = tx_index;
    push               = 1'b0;
    op                 = '0;
    waddr              = '0;
    raddr              = '0;
    start              = (rx_phase == PH_READY) || (rx_phase == PH_TAIL);
    base_count         = start ? '0 : rx_count;
    base_ovf           = start ? 1'b0 : rx_overflowed;
    count_new          = base_count;
    ovf_new            = base_ovf;
    complete           = 1'b0;

    if (accept) begin
      if (in_item.command == CMD_TX_READY) begin
        if (tx_remaining != '0) begin
          push              = 1'b1;
          op.send           = 1'b1;
          op.rd             = tx_index < CW'(BUF_DEPTH);
          raddr             = bank_addr(~bank_select, tx_index);
          tx_remaining_next = tx_remaining - 1'b1;
          if (op.rd) tx_index_next = tx_index + 1'b1;
        end
      end else begin
        if (base_count < CW'(BUF_DEPTH)) begin
          op.wr     = 1'b1;
          op.wdata  = in_item.rx_byte;
          waddr     = bank_addr(bank_select, base_count);
          count_new = base_count + 1'b1;
        end else begin
          ovf_new = 1'b1;
        end
        rx_count_next      = count_new;
        rx_overflowed_next = ovf_new;

        unique case (rx_phase)
          PH_READY, PH_TAIL: rx_phase_next = PH_RECEIVING;
          PH_RECEIVING: begin
            if (in_item.rx_byte == tail_first) rx_phase_next = PH_HALF;
          end
          PH_HALF: begin
            priority if (in_item.rx_byte == tail_second) begin
              rx_phase_next = PH_TAIL;
              complete      = 1'b1;
            end else if (in_item.rx_byte == tail_first) begin
              rx_phase_next = PH_HALF;
            end else begin
              rx_phase_next = PH_RECEIVING;
            end
          end
          default: rx_phase_next = PH_RECEIVING;
        endcase

        if (complete) begin
          op.done = 1'b1;
          op.len  = 7'(count_new);
          op.ovf  = ovf_new;
          // echo starts only when the transmitter side is idle
          if (tx_remaining == '0 && count_new != '0) begin
            op.send           = 1'b1;
            op.rd             = 1'b1;
            raddr             = bank_addr(bank_select, '0);
            tx_remaining_next = count_new - 1'b1;
            tx_index_next     = CW'(1);
            bank_select_next  = ~bank_select;
          end
        end
        push = op.wr || complete;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= PH_READY;
      rx_count      <= '0;
      rx_overflowed <= 1'b0;
      bank_select   <= 1'b0;
      tx_remaining  <= '0;
      tx_index      <= '0;
      tail_first    <= TAIL_FIRST_RESET;
      tail_second   <= TAIL_SECOND_RESET;
    end else begin
      rx_phase      <= rx_phase_next;
      rx_count      <= rx_count_next;
      rx_overflowed <= rx_overflowed_next;
      bank_select   <= bank_select_next;
      tx_remaining  <= tx_remaining_next;
      tx_index      <= tx_index_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TAIL_FIRST:  tail_first  <= cfg_data;
          REG_TAIL_SECOND: tail_second <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/tfrx_queue.sv
// short fifo of operations between the front and the back
`default_nettype none

module tfrx_queue
  import tfrx_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    head, tail;
  logic [PW:0]      fill;
  logic             do_wr, do_rd;

  assign wr_ready = fill != (PW + 1)'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[head];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) slots[tail] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_wr) tail <= (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      if (do_rd) head <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/tfrx_back.sv
// back part: frame bank memory and result register
`default_nettype none

module tfrx_back
  import tfrx_pkg::*;
#(
  parameter int BUF_DEPTH = 64,
  parameter int AW        = $clog2(2 * BUF_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  output logic               op_ready,
  input  wire op_t           op,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] raddr,
  output logic               out_valid,
  input  wire logic          out_ready,
  output out_item_t          out_item
);

  logic [7:0] frame_banks [2 * BUF_DEPTH];
  logic [7:0] rd_data;
  logic       has_result;
  logic       out_free;
  logic       pop;
  logic       res_send, res_rd, res_done, res_ovf;
  logic [6:0] res_len;

  assign has_result = op.send || op.done;
  assign out_free   = !out_valid || out_ready;
  // write-only items drain even while a result waits
  assign op_ready   = !has_result || out_free;
  assign pop        = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (pop && op.wr) frame_banks[waddr] <= op.wdata;
    if (pop && op.rd) rd_data <= frame_banks[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      res_send <= op.send;
      res_rd   <= op.rd;
      res_done <= op.done;
      res_len  <= op.len;
      res_ovf  <= op.ovf;
    end
  end

  always_comb begin
    out_item            = '0;
    out_item.tx_valid   = res_send;
    out_item.tx_byte    = res_rd ? rd_data : 8'd0;
    out_item.frame_done = res_done;
    out_item.frame_size = res_done ? res_len : 7'd0;
    out_item.overflow   = res_done && res_ovf;
  end

endmodule

`default_nettype wire

>>> sim/tfrx_echo_checker.sv
// result checker for the tail framed receiver: frame and echo model, in-order compare
`default_nettype none

module tfrx_echo_checker
  import tfrx_pkg::*;
#(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire in_item_t               in_item,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire out_item_t              out_item,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data,
  output int                          errors,
  output int                          outstanding,
  output int                          n_events,
  output int                          n_results,
  output int                          n_frames,
  output int                          n_echoes,
  output int                          n_overflows
);

  typedef enum logic [1:0] {RX_IDLE, RX_BODY, RX_HALF, RX_TAIL} rx_phase_t;

  logic [7:0] tail_a;
  logic [7:0] tail_b;
  rx_phase_t  phase;
  logic [6:0] fill;
  logic       over;
  logic [7:0] banks [2*BUF_DEPTH];
  logic       fill_bank;
  logic [6:0] tx_left;
  logic [6:0] tx_pos;
  out_item_t  due_results[$];
  out_item_t  want;

  task automatic keep_byte(input logic [7:0] b);
    if (fill < BUF_DEPTH) begin
      banks[int'(fill_bank) * BUF_DEPTH + int'(fill)] = b;
      fill = fill + 7'd1;
    end else begin
      over = 1'b1;
    end
  endtask

  // advance the frame and echo state by one item, queue the result it causes
  task automatic take_event(input in_item_t it);
    out_item_t r;
    bit        made;
    r = '0;
    made = 1'b0;
    if (it.command == CMD_TX_READY) begin
      if (tx_left != 0) begin
        r.tx_valid = 1'b1;
        if (tx_pos < BUF_DEPTH)
          r.tx_byte = banks[int'(fill_bank ^ 1'b1) * BUF_DEPTH + int'(tx_pos)];
        tx_left = tx_left - 7'd1;
        if (tx_pos < BUF_DEPTH) tx_pos = tx_pos + 7'd1;
        made = 1'b1;
      end
    end else if (phase == RX_IDLE || phase == RX_TAIL) begin
      // first byte of a frame is never a terminator candidate
      fill = '0;
      over = 1'b0;
      keep_byte(it.rx_byte);
      phase = RX_BODY;
    end else begin
      keep_byte(it.rx_byte);
      if (phase == RX_BODY) begin
        if (it.rx_byte == tail_a) phase = RX_HALF;
      end else begin
        if (it.rx_byte == tail_b) phase = RX_TAIL;
        else if (it.rx_byte == tail_a) phase = RX_HALF;
        else phase = RX_BODY;
        if (phase == RX_TAIL) begin
          r.frame_done = 1'b1;
          r.frame_size = fill;
          r.overflow = over;
          made = 1'b1;
          n_frames++;
          if (over) n_overflows++;
          // echo only when the transmitter has nothing left, then swap banks
          if (tx_left == 0 && fill > 0) begin
            r.tx_valid = 1'b1;
            r.tx_byte = banks[int'(fill_bank) * BUF_DEPTH];
            tx_left = fill - 7'd1;
            tx_pos = 7'd1;
            fill_bank = fill_bank ^ 1'b1;
            n_echoes++;
          end
        end
      end
    end
    if (made) due_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tail_a = TAIL_FIRST_RESET;
      tail_b = TAIL_SECOND_RESET;
      phase = RX_IDLE;
      fill = '0;
      over = 1'b0;
      fill_bank = 1'b0;
      tx_left = '0;
      tx_pos = '0;
      due_results.delete();
      foreach (banks[i]) banks[i] = 8'h00;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_TAIL_FIRST) tail_a = cfg_data;
        else if (cfg_index == REG_TAIL_SECOND) tail_b = cfg_data;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: %h", out_item);
          errors++;
        end else begin
          want = due_results.pop_front();
          compare_field("tx_valid", 8'(want.tx_valid), 8'(out_item.tx_valid));
          compare_field("tx_byte", want.tx_byte, out_item.tx_byte);
          compare_field("frame_done", 8'(want.frame_done), 8'(out_item.frame_done));
          compare_field("frame_size", 8'(want.frame_size), 8'(out_item.frame_size));
          compare_field("overflow", 8'(want.overflow), 8'(out_item.overflow));
        end
      end
      if (in_valid && in_ready) begin
        n_events++;
        take_event(in_item);
      end
    end
    outstanding <= due_results.size();
  end

endmodule

`default_nettype wire

>>> sim/tb_tail_framed_receiver_with_echo.sv
// testbench top for the tail framed receiver: stimulus, stalls and verdict
`default_nettype none

module tb_tail_framed_receiver_with_echo;
  import tfrx_pkg::*;

  localparam int BUF_DEPTH   = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 800;
  localparam int SETTLE      = 12;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_item;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;

  int errors, outstanding, n_events, n_results, n_frames, n_echoes, n_overflows;
  int cycles = 0;
  int stall_left = 0;
  int items_sent = 0;
  logic gaps_on;
  logic [7:0] term_a = TAIL_FIRST_RESET;
  logic [7:0] term_b = TAIL_SECOND_RESET;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tail_framed_receiver_with_echo #(.BUF_DEPTH(BUF_DEPTH)) dut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_write, .cfg_index, .cfg_data
  );

  tfrx_echo_checker #(.BUF_DEPTH(BUF_DEPTH)) chk (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_write, .cfg_index, .cfg_data, .errors, .outstanding, .n_events, .n_results,
    .n_frames, .n_echoes, .n_overflows
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tail_framed_receiver_with_echo verification failed");
      $finish;
    end
  end

  // receiver back-pressure in bursts of random length while gaps are on
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_event(input logic cmd, input logic [7:0] b);
    in_valid <= 1'b1;
    in_item <= '{command: cmd, rx_byte: b};
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic echo_readies(input int n);
    repeat (n) send_event(CMD_TX_READY, 8'($urandom_range(0, 255)));
  endtask

  // random body with the odd ready notice mixed in, closed by the terminator
  task automatic send_frame(input int body_len);
    repeat (body_len) begin
      if ($urandom_range(0, 7) == 0) echo_readies(1);
      send_event(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
    end
    send_event(CMD_RX_BYTE, term_a);
    send_event(CMD_RX_BYTE, term_b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // items with no result may still sit in the block's queue
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_tail(input logic [7:0] a, input logic [7:0] b);
    cfg_write <= 1'b1;
    cfg_index <= REG_TAIL_FIRST;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= REG_TAIL_SECOND;
    cfg_data <= b;
    @(posedge clk);
    cfg_write <= 1'b0;
    term_a = a;
    term_b = b;
  endtask

  initial begin
    int ph;
    int start;
    int len;
    int pick;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_TAIL_FIRST;
    cfg_data <= '0;
    gaps_on <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset terminator, short frame echoed, then one ready too many
    send_event(CMD_RX_BYTE, 8'h41);
    send_event(CMD_RX_BYTE, 8'h0D);
    send_event(CMD_RX_BYTE, 8'h0A);
    echo_readies(3);
    // terminator bytes heading a frame are plain data
    send_event(CMD_RX_BYTE, 8'h0D);
    send_event(CMD_RX_BYTE, 8'h0A);
    send_event(CMD_RX_BYTE, 8'h0D);
    send_event(CMD_RX_BYTE, 8'h0A);
    // frame completed while the echo is busy, repeated first tail byte
    send_event(CMD_RX_BYTE, 8'h00);
    send_event(CMD_RX_BYTE, 8'hFF);
    send_event(CMD_RX_BYTE, 8'h0D);
    send_event(CMD_RX_BYTE, 8'h0D);
    send_event(CMD_RX_BYTE, 8'h0A);
    echo_readies(4);
    send_event(CMD_RX_BYTE, 8'hFF);
    send_event(CMD_RX_BYTE, 8'h0D);
    send_event(CMD_RX_BYTE, 8'h0A);

    for (ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: set_tail(8'h00, 8'hFF);
        1: set_tail(8'hFF, 8'h00);
        2: set_tail(8'h55, 8'h55);
        4: set_tail(8'h00, 8'h00);
        5: set_tail(8'hFF, 8'hFF);
        7: set_tail(TAIL_FIRST_RESET, TAIL_SECOND_RESET);
        default: set_tail(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      if (ph == 7) gaps_on <= 1'b0;
      start = items_sent;
      while (items_sent - start < ITEM_TARGET / 8) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          // mostly short frames, now and then a long one that may pass the buffer capacity
          len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 10);
          send_frame(len);
          echo_readies($urandom_range(0, len + 3));
        end else if (pick < 16) begin
          repeat ($urandom_range(1, 6))
            send_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              send_event(CMD_RX_BYTE, term_a);
              send_event(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
            end
            1: send_event(CMD_RX_BYTE, term_b);
            default: begin
              send_event(CMD_RX_BYTE, term_a);
              send_event(CMD_RX_BYTE, term_a);
              send_event(CMD_RX_BYTE, term_b);
            end
          endcase
        end
        if ($urandom_range(0, 29) == 0) drain();
      end
    end
    drain();

    $display("run covered %0d items and %0d checked results over eight terminator settings",
             n_events, n_results);
    $display("frames: %0d completed, %0d echoed, %0d over capacity",
             n_frames, n_echoes, n_overflows);
    if (errors == 0)
      $display("tail_framed_receiver_with_echo verification clean");
    else
      $display("tail_framed_receiver_with_echo verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> tail_framed_receiver_with_echo.f
sv/tfrx_pkg.sv
sv/tfrx_front.sv
sv/tfrx_queue.sv
sv/tfrx_back.sv
sv/tail_framed_receiver_with_echo.sv
sim/tfrx_echo_checker.sv
sim/tb_tail_framed_receiver_with_echo.sv
